FILE: design/aip_pkg.sv
package aip_pkg;

    localparam int CharW  = 8;
    localparam int ValueW = 32;
    localparam int BaseW  = 6;

    localparam logic [BaseW-1:0] BaseMax  = 6'd36;
    localparam logic [BaseW-1:0] BaseDec  = 6'd10;
    localparam logic [BaseW-1:0] BaseHex  = 6'd16;
    localparam logic [BaseW-1:0] BaseBin  = 6'd2;
    localparam logic [BaseW-1:0] ModeAuto = 6'd0;

    localparam logic [CharW-1:0] ChSpace  = 8'h20;
    localparam logic [CharW-1:0] ChTab    = 8'h09;
    localparam logic [CharW-1:0] ChCr     = 8'h0D;
    localparam logic [CharW-1:0] ChLf     = 8'h0A;
    localparam logic [CharW-1:0] ChZero   = 8'h30;
    localparam logic [CharW-1:0] ChNine   = 8'h39;
    localparam logic [CharW-1:0] ChHigh   = 8'h80;
    localparam logic [CharW-1:0] ChUpperA = 8'h41;
    localparam logic [CharW-1:0] ChCaseB  = 8'h20;
    localparam logic [CharW-1:0] ChMinus  = 8'h2D;
    localparam logic [CharW-1:0] ChPlus   = 8'h2B;
    localparam logic [CharW-1:0] ChDollar = 8'h24;
    localparam logic [CharW-1:0] ChPct    = 8'h25;
    localparam logic [CharW-1:0] ChLowX   = 8'h78;
    localparam logic [CharW-1:0] ChUpX    = 8'h58;
    localparam logic [CharW-1:0] ChLowB   = 8'h62;

    typedef struct packed {
        logic [ValueW-1:0] acc;
        logic              negate;
        logic              digit_seen;
        logic              prefix_allowed;
        logic [BaseW-1:0]  base;
        logic              skipping;
    } aip_state_t;

    typedef struct packed {
        logic [CharW-1:0]  end_char;
        logic [BaseW-1:0]  success_base;
        logic [ValueW-1:0] value;
    } aip_result_t;

    function automatic aip_state_t aip_restart(input logic [BaseW-1:0] mode);
        aip_state_t       s;
        logic [BaseW-1:0] b;
        b = (mode > BaseMax) ? BaseMax : mode;
        s.acc            = '0;
        s.negate         = 1'b0;
        s.digit_seen     = 1'b0;
        s.skipping       = 1'b1;
        s.prefix_allowed = (b == ModeAuto);
        s.base           = (b == ModeAuto) ? BaseDec : b;
        return s;
    endfunction

endpackage

FILE: design/aip_step.sv
module aip_step (
    input  logic [7:0]          c,
    input  logic [5:0]          base_mode,
    input  aip_pkg::aip_state_t st,
    output aip_pkg::aip_state_t st_next,
    output logic                finish,
    output aip_pkg::aip_result_t result
);
    import aip_pkg::*;

    logic                blank;
    logic                add;
    logic [BaseW-1:0]    digit;
    logic [CharW-1:0]    u;
    logic [CharW-1:0]    letter;
    logic [ValueW+BaseW-1:0] prod;

    assign blank   = (c == ChSpace) || (c == ChTab);
    assign u       = c & ~ChCaseB;
    assign letter  = u - ChUpperA + {2'b00, BaseDec};
    assign prod    = {{BaseW{1'b0}}, st.acc} * {{ValueW{1'b0}}, st.base};

    assign result.value        = st.negate ? (~st.acc + 32'd1) : st.acc;
    assign result.success_base = st.digit_seen ? st.base : '0;
    assign result.end_char     = c;

    always_comb
    begin
        st_next = st;
        finish  = 1'b0;
        add     = 1'b0;
        digit   = '0;
        if (!(st.skipping && blank))
        begin
            st_next.skipping = 1'b0;
            if (c inside {[ChZero:ChNine]})
            begin
                if ({2'b00, c[3:0]} < st.base)
                begin
                    add   = 1'b1;
                    digit = {2'b00, c[3:0]};
                end
                else
                    finish = 1'b1;
            end
            else if (blank || c == ChCr || c == ChLf)
                finish = 1'b1;
            else if (c < ChSpace || c >= ChHigh)
                ;
            else if (st.base > BaseDec)
            begin
                if (u >= ChUpperA && letter < {2'b00, st.base})
                begin
                    add   = 1'b1;
                    digit = letter[BaseW-1:0];
                end
                else
                    finish = 1'b1;
            end
            else if (st.acc == '0)
            begin
                if (!st.digit_seen)
                begin
                    if (c == ChMinus)
                        st_next.negate = !st.negate;
                    else if (c == ChPlus)
                        ;
                    else if (st.prefix_allowed && c == ChDollar)
                    begin
                        st_next.base           = BaseHex;
                        st_next.prefix_allowed = 1'b0;
                    end
                    else if (st.prefix_allowed && c == ChPct)
                    begin
                        st_next.base           = BaseBin;
                        st_next.prefix_allowed = 1'b0;
                    end
                    else
                        finish = 1'b1;
                end
                else if (st.prefix_allowed)
                begin
                    if (c == ChLowX || c == ChUpX)
                    begin
                        st_next.base           = BaseHex;
                        st_next.prefix_allowed = 1'b0;
                    end
                    else if (c == ChLowB)
                    begin
                        st_next.base           = BaseBin;
                        st_next.prefix_allowed = 1'b0;
                    end
                    else
                        finish = 1'b1;
                end
            end
        end
        if (add)
        begin
            st_next.acc        = prod[ValueW-1:0] + {{(ValueW-BaseW){1'b0}}, digit};
            st_next.digit_seen = 1'b1;
        end
        if (finish)
            st_next = aip_restart(base_mode);
    end

endmodule

FILE: design/aip_out_reg.sv
module aip_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  aip_pkg::aip_result_t result,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata
);
    import aip_pkg::*;

    logic        valid_reg;
    aip_result_t data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= result;
    end

endmodule

FILE: design/ascii_integer_parser.sv
// Multiply-add is combinational; m_tvalid follows s1_char_reg and then the output register.
// Throughput: one character per cycle, stalled when a number ends and the output is full.
// Parsing that ends with no digit still emits a transaction, with success_base 0.
// Reset (rst_n, asynchronous, active low): auto base mode, parser restarted, pipeline empty.
// A base_mode write restarts the parser and drops any number in progress.
module ascii_integer_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,   // base_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata        // [31:0] value, [37:32] success_base, [45:38] end_char
);
    import aip_pkg::*;

    logic             s1_valid_reg;
    logic [CharW-1:0] s1_char_reg;
    logic [BaseW-1:0] base_mode_reg;
    aip_state_t       state_reg;
    aip_state_t       state_next;
    aip_result_t      result;
    logic             finish;
    logic             out_free;
    logic             advance;

    aip_step u_step (
        .c         (s1_char_reg),
        .base_mode (base_mode_reg),
        .st        (state_reg),
        .st_next   (state_next),
        .finish    (finish),
        .result    (result)
    );

    aip_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (s1_valid_reg && finish),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign advance  = s1_valid_reg && (!finish || out_free);
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            base_mode_reg <= ModeAuto;
            state_reg     <= aip_restart(ModeAuto);
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (cfg_wr_en)
            begin
                base_mode_reg <= cfg_wr_data;
                state_reg     <= aip_restart(cfg_wr_data);
            end
            else if (advance)
                state_reg <= state_next;
        end
    end

    // hold the character until the step logic consumes it
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            s1_char_reg <= s_tdata;
    end

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.base != 6'd0 && state_reg.base <= BaseMax)
        else $error("current base out of range");

    a_acc_without_digit: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.digit_seen |-> state_reg.acc == '0)
        else $error("accumulator nonzero before any digit");

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.skipping |-> (!state_reg.digit_seen && !state_reg.negate))
        else $error("leading skip with number in progress");

    a_prefix_auto: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.prefix_allowed |-> base_mode_reg == ModeAuto)
        else $error("prefix allowed outside auto mode");

endmodule
